// ===== sv/lipsf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lipsf_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int NOW_WIDTH      = 32;
    localparam int DUR_WIDTH      = 16;
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH = 16;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_ENABLE        = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_WAKE_TIME     = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_POLL_INTERVAL = 2'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SAMPLE_WINDOW = 2'd3;

    localparam logic                 RST_ENABLE        = 1'b0;
    localparam logic [DUR_WIDTH-1:0] RST_WAKE_TIME     = 16'd100;
    localparam logic [DUR_WIDTH-1:0] RST_POLL_INTERVAL = 16'd1000;
    localparam logic [DUR_WIDTH-1:0] RST_SAMPLE_WINDOW = 16'd100;

    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_WAKE   = 1'b1;

    // power state codes as seen on the result port
    localparam logic [1:0] PS_AWAKE  = 2'd0;
    localparam logic [1:0] PS_DOWN   = 2'd1;
    localparam logic [1:0] PS_WAKING = 2'd2;
    localparam logic [1:0] PS_POLL   = 2'd3;

    typedef enum logic [3:0] {
        S_AWAKE  = 4'b0001,
        S_DOWN   = 4'b0010,
        S_WAKING = 4'b0100,
        S_POLL   = 4'b1000
    } t_pstate;

    typedef struct packed {
        logic                 enable;
        logic [DUR_WIDTH-1:0] wake_time;
        logic [DUR_WIDTH-1:0] poll_interval;
        logic [DUR_WIDTH-1:0] sample_window;
    } t_cfg;

    typedef struct packed {
        t_pstate state;
        logic    load;
    } t_step;

    function automatic logic [1:0] state_code(t_pstate s);
        logic [1:0] c;
        c = PS_AWAKE;
        unique case (s)
            S_AWAKE:  c = PS_AWAKE;
            S_DOWN:   c = PS_DOWN;
            S_WAKING: c = PS_WAKING;
            S_POLL:   c = PS_POLL;
            default:  c = PS_AWAKE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/lipsf_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lipsf_cfg (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [lipsf_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_index,
    input  wire logic [lipsf_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data,
    output lipsf_pkg::t_cfg                          o_cfg
);
    import lipsf_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable        <= RST_ENABLE;
            r_cfg.wake_time     <= RST_WAKE_TIME;
            r_cfg.poll_interval <= RST_POLL_INTERVAL;
            r_cfg.sample_window <= RST_SAMPLE_WINDOW;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ENABLE:        r_cfg.enable        <= i_cfg_data[0];
                CFG_WAKE_TIME:     r_cfg.wake_time     <= i_cfg_data[DUR_WIDTH-1:0];
                CFG_POLL_INTERVAL: r_cfg.poll_interval <= i_cfg_data[DUR_WIDTH-1:0];
                CFG_SAMPLE_WINDOW: r_cfg.sample_window <= i_cfg_data[DUR_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== sv/lipsf_next.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lipsf_next #(
    parameter int TIME_WIDTH = lipsf_pkg::TIME_WIDTH_DEF
) (
    input  wire lipsf_pkg::t_cfg                 i_cfg,
    input  wire lipsf_pkg::t_pstate              i_state,
    input  wire logic [TIME_WIDTH-1:0]            i_changed_at,
    input  wire logic                            i_req_type,
    input  wire logic [TIME_WIDTH-1:0]            i_now,
    input  wire logic                            i_must_stay_awake,
    input  wire logic                            i_off_hook,
    output lipsf_pkg::t_step                     o_step
);
    import lipsf_pkg::*;

    logic [TIME_WIDTH-1:0] elapsed;
    logic                  wake_done;
    logic                  poll_done;
    logic                  window_done;
    t_step                 step;

    // wrapping elapsed time since the last state change
    assign elapsed     = i_now - i_changed_at;
    assign wake_done   = elapsed >= TIME_WIDTH'(i_cfg.wake_time);
    assign poll_done   = elapsed >= TIME_WIDTH'(i_cfg.poll_interval);
    assign window_done = elapsed >= TIME_WIDTH'(i_cfg.sample_window);

    always_comb begin
        step.state = i_state;
        step.load  = 1'b0;
        if (i_req_type == REQ_WAKE) begin
            unique case (i_state)
                S_DOWN:  step = '{state: S_WAKING, load: 1'b1};
                S_POLL:  step = '{state: S_AWAKE,  load: 1'b1};
                default: ;
            endcase
        end else if (!i_cfg.enable) begin
            // disabled: only move back towards awake
            unique case (i_state)
                S_DOWN:   step = '{state: S_WAKING, load: 1'b1};
                S_WAKING,
                S_POLL: begin
                    if (wake_done) step = '{state: S_AWAKE, load: 1'b1};
                end
                default: ;
            endcase
        end else if (i_must_stay_awake || i_off_hook) begin
            unique case (i_state)
                S_DOWN:   step = '{state: S_WAKING, load: 1'b1};
                S_WAKING: begin
                    if (wake_done) step = '{state: S_AWAKE, load: 1'b1};
                end
                S_POLL:   step = '{state: S_AWAKE, load: 1'b1};
                default: ;
            endcase
        end else begin
            unique case (i_state)
                S_AWAKE:  step = '{state: S_DOWN, load: 1'b1};
                S_DOWN: begin
                    if (poll_done) step = '{state: S_WAKING, load: 1'b1};
                end
                S_WAKING: begin
                    if (wake_done) step = '{state: S_POLL, load: 1'b1};
                end
                S_POLL: begin
                    if (window_done) step = '{state: S_DOWN, load: 1'b1};
                end
                default: ;
            endcase
        end
    end

    assign o_step = step;

endmodule

`default_nettype wire

// ===== sv/line_interface_power_saving_fsm_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel  | valid        | stall        | payload
// ---------+--------------+--------------+-------------------------------------------
// input    | i_in_valid   | o_in_stall   | i_req_type i_now_ms i_must_stay_awake i_off_hook
// result   | o_out_valid  | i_out_stall  | o_power_state o_power_down_driven o_hook_valid
// config   | i_cfg_we     | (none)       | i_cfg_index i_cfg_data
//
// one item per cycle unless the result stalls; an input transfer is registered
// in the input register, then goes through next-state logic into the result register
// the power state and change time are updated as an item enters the result register
// i_rst_n is synchronous; it clears both valid flags and resets the state and the config
// a stalled result holds and the input register backs up behind it

module line_interface_power_saving_fsm_core #(
    parameter int TIME_WIDTH = lipsf_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic                                i_req_type,
    input  wire logic [lipsf_pkg::NOW_WIDTH-1:0]      i_now_ms,
    input  wire logic                                i_must_stay_awake,
    input  wire logic                                i_off_hook,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [1:0]                               o_power_state,
    output logic                                     o_power_down_driven,
    output logic                                     o_hook_valid,
    input  wire logic                                i_cfg_we,
    input  wire logic [lipsf_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_index,
    input  wire logic [lipsf_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data
);
    import lipsf_pkg::*;

    t_cfg                  cfg;
    t_step                 step;
    logic [TIME_WIDTH-1:0] now_t;
    logic                  out_ready;
    logic                  in_ready;
    logic                  advance;

    logic                  r_in_valid;
    logic                  r_in_req;
    logic [NOW_WIDTH-1:0]  r_in_now;
    logic                  r_in_stay;
    logic                  r_in_hook;

    t_pstate               r_state;
    logic [TIME_WIDTH-1:0] r_changed_at;

    logic                  r_out_valid;
    logic [1:0]            r_out_state;
    logic                  r_out_pd;
    logic                  r_out_hv;

    lipsf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // time taken modulo 2^TIME_WIDTH
    generate
        if (TIME_WIDTH > NOW_WIDTH) begin : g_wide
            assign now_t = {{(TIME_WIDTH-NOW_WIDTH){1'b0}}, r_in_now};
        end else begin : g_narrow
            assign now_t = r_in_now[TIME_WIDTH-1:0];
        end
    endgenerate

    lipsf_next #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_next (
        .i_cfg             (cfg),
        .i_state           (r_state),
        .i_changed_at      (r_changed_at),
        .i_req_type        (r_in_req),
        .i_now             (now_t),
        .i_must_stay_awake (r_in_stay),
        .i_off_hook        (r_in_hook),
        .o_step            (step)
    );

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_ready;
    assign in_ready   = !r_in_valid || out_ready;
    assign o_in_stall = !in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in_valid) begin
            r_in_req  <= i_req_type;
            r_in_now  <= i_now_ms;
            r_in_stay <= i_must_stay_awake;
            r_in_hook <= i_off_hook;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_AWAKE;
            r_changed_at <= '0;
        end else if (advance && step.load) begin
            r_state      <= step.state;
            r_changed_at <= now_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_state <= state_code(step.state);
            r_out_pd    <= (step.state == S_DOWN);
            r_out_hv    <= (step.state == S_AWAKE) || (step.state == S_POLL);
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_power_state       = r_out_state;
    assign o_power_down_driven = r_out_pd;
    assign o_hook_valid        = r_out_hv;

endmodule

`default_nettype wire
